// File: rtl/ps2md_pkg.sv
// Package for the PS/2 mouse packet decoder: codes, constants and the queue item type.
package ps2md_pkg;

    localparam logic [1:0] EV_MOVE   = 2'd0;
    localparam logic [1:0] EV_BUTTON = 2'd1;
    localparam logic [1:0] EV_SCROLL = 2'd2;

    localparam int MASK_MOVE   = 0;
    localparam int MASK_BUTTON = 1;
    localparam int MASK_SCROLL = 2;

    localparam int SYNC_BIT   = 3;
    localparam int X_SIGN_BIT = 4;
    localparam int Y_SIGN_BIT = 5;
    localparam int X_OVF_BIT  = 6;
    localparam int Y_OVF_BIT  = 7;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0]        mask;
        logic signed [8:0] dx;
        logic signed [9:0] dy;
        logic signed [7:0] dz;
        logic [2:0]        buttons;
    } ps2md_cmd_t;

endpackage

// File: rtl/ps2md_front.sv
// Front part: packet assembly, sync check, sign extension and event classification.
module ps2md_front
    import ps2md_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wheel_mode,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    input  logic       queue_full,
    output logic       push,
    output ps2md_cmd_t push_cmd
);

    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic [2:0] last_buttons_reg;
    logic [2:0] last_buttons_next;
    logic [7:0] pkt_reg [0:2];

    logic       accept;
    logic       complete;
    logic [7:0] flags;
    logic [7:0] byte_y;
    logic signed [9:0] dy_ext;
    logic       overflow;
    ps2md_cmd_t cmd;

    assign rx_stall = queue_full;
    assign accept   = rx_valid && !queue_full;

    always_comb
    begin
        flags    = pkt_reg[0];
        byte_y   = (pos_reg == POS_THIRD) ? rx_byte : pkt_reg[2];
        complete = (pos_reg == POS_FOURTH) || (pos_reg == POS_THIRD && !wheel_mode);
        overflow = flags[X_OVF_BIT] || flags[Y_OVF_BIT];

        cmd.dx      = {flags[X_SIGN_BIT], pkt_reg[1]};
        dy_ext      = {{2{flags[Y_SIGN_BIT]}}, byte_y};
        cmd.dy      = -dy_ext;
        cmd.dz      = (wheel_mode && pos_reg == POS_FOURTH) ? rx_byte : 8'sd0;
        cmd.buttons = flags[2:0];

        cmd.mask = 3'b000;
        cmd.mask[MASK_MOVE]   = (cmd.dx != 9'sd0) || (cmd.dy != 10'sd0);
        cmd.mask[MASK_BUTTON] = (cmd.buttons != last_buttons_reg);
        cmd.mask[MASK_SCROLL] = (cmd.dz != 8'sd0);

        pos_next          = pos_reg;
        last_buttons_next = last_buttons_reg;
        push              = 1'b0;
        if (accept)
        begin
            if (pos_reg == POS_FIRST && !rx_byte[SYNC_BIT])
            begin
                pos_next = POS_FIRST;
            end
            else if (complete)
            begin
                pos_next = POS_FIRST;
                if (!overflow)
                begin
                    push = (cmd.mask != 3'b000);
                    last_buttons_next = cmd.buttons;
                end
            end
            else
            begin
                pos_next = pos_reg + 2'd1;
            end
        end
    end

    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= POS_FIRST;
            last_buttons_reg <= 3'b000;
        end
        else
        begin
            pos_reg          <= pos_next;
            last_buttons_reg <= last_buttons_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && pos_reg != POS_FOURTH && !(pos_reg == POS_FIRST && !rx_byte[SYNC_BIT]))
        begin
            pkt_reg[pos_reg] <= rx_byte;
        end
    end

endmodule

// File: rtl/ps2md_queue.sv
// Two-entry queue of classified packets between front and back.
module ps2md_queue
    import ps2md_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  ps2md_cmd_t push_cmd,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output ps2md_cmd_t head_cmd
);

    ps2md_cmd_t entry_reg [0:QUEUE_DEPTH-1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'(QUEUE_DEPTH));
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/ps2md_back.sv
// Back part: issues the events of each queued packet in order through an output register.
module ps2md_back
    import ps2md_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  ps2md_cmd_t        head_cmd,
    output logic              pop,
    output logic              event_valid,
    input  logic              event_stall,
    output logic [1:0]        event_kind,
    output logic signed [8:0] delta_x,
    output logic signed [9:0] delta_y,
    output logic signed [7:0] delta_wheel,
    output logic [2:0]        button_bits,
    output logic              last_event
);

    logic [2:0] done_reg;
    logic [2:0] done_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [1:0] kind_reg;
    logic signed [8:0] dx_reg;
    logic signed [9:0] dy_reg;
    logic signed [7:0] dz_reg;
    logic [2:0] buttons_reg;
    logic       last_reg;

    logic [2:0] pending;
    logic [2:0] sel;
    logic       load;
    logic       fire;
    logic       is_last;
    logic [1:0] kind_sel;

    always_comb
    begin
        pending = head_cmd.mask & ~done_reg;
        sel      = 3'b000;
        kind_sel = EV_MOVE;
        priority if (pending[MASK_MOVE])
        begin
            sel[MASK_MOVE] = 1'b1;
            kind_sel       = EV_MOVE;
        end
        else if (pending[MASK_BUTTON])
        begin
            sel[MASK_BUTTON] = 1'b1;
            kind_sel         = EV_BUTTON;
        end
        else
        begin
            sel[MASK_SCROLL] = 1'b1;
            kind_sel         = EV_SCROLL;
        end
        is_last = ((pending & ~sel) == 3'b000);
        load    = !out_valid_reg || !event_stall;
        fire    = head_valid && load;
        pop     = fire && is_last;

        done_next = done_reg;
        if (fire)
        begin
            done_next = is_last ? 3'b000 : (done_reg | sel);
        end

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = fire;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 3'b000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            kind_reg    <= kind_sel;
            dx_reg      <= (kind_sel == EV_MOVE) ? head_cmd.dx : 9'sd0;
            dy_reg      <= (kind_sel == EV_MOVE) ? head_cmd.dy : 10'sd0;
            dz_reg      <= (kind_sel == EV_SCROLL) ? head_cmd.dz : 8'sd0;
            buttons_reg <= head_cmd.buttons;
            last_reg    <= is_last;
        end
    end

    assign event_valid = out_valid_reg;
    assign event_kind  = kind_reg;
    assign delta_x     = dx_reg;
    assign delta_y     = dy_reg;
    assign delta_wheel = dz_reg;
    assign button_bits = buttons_reg;
    assign last_event  = last_reg;

endmodule

// File: rtl/ps2_mouse_packet_decoder.sv
// PS/2 mouse packet decoder top level: configuration register and front/queue/back wiring.
// Accepts one received mouse byte per cycle while rx_stall is low and gathers three-byte
// packets, or four-byte packets with a scroll byte when wheel_mode is set; out-of-sync
// first bytes and overflow packets are dropped. Each complete packet yields up to three
// events (move, button change, scroll), issued one per cycle from an output register
// while event_stall is low. A two-entry packet queue sits between byte assembly and event
// issue; rx_stall rises only when that queue is full. wheel_mode is written through the
// cfg port, which is always ready, and should be changed only while the decoder is idle.
module ps2_mouse_packet_decoder
    import ps2md_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    input  logic              rx_valid,
    output logic              rx_stall,
    input  logic [7:0]        rx_byte,
    output logic              event_valid,
    input  logic              event_stall,
    output logic [1:0]        event_kind,
    output logic signed [8:0] delta_x,
    output logic signed [9:0] delta_y,
    output logic signed [7:0] delta_wheel,
    output logic [2:0]        button_bits,
    output logic              last_event
);

    logic       wheel_mode_reg;
    logic       wheel_mode_next;
    logic       push;
    ps2md_cmd_t push_cmd;
    logic       queue_full;
    logic       pop;
    logic       head_valid;
    ps2md_cmd_t head_cmd;

    assign cfg_ready       = 1'b1;
    assign wheel_mode_next = (cfg_valid && cfg_ready) ? cfg_data : wheel_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_mode_reg <= 1'b0;
        end
        else
        begin
            wheel_mode_reg <= wheel_mode_next;
        end
    end

    ps2md_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .wheel_mode (wheel_mode_reg),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .rx_byte    (rx_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    ps2md_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    ps2md_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_kind  (event_kind),
        .delta_x     (delta_x),
        .delta_y     (delta_y),
        .delta_wheel (delta_wheel),
        .button_bits (button_bits),
        .last_event  (last_event)
    );

endmodule

// File: tb/mouse_event_checker.sv
// Checker for the PS/2 mouse packet decoder: predicts events from accepted bytes and compares them.
`timescale 1ns / 1ps

module mouse_event_checker
    import ps2md_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic              cfg_data,
    input  logic              rx_valid,
    input  logic              rx_stall,
    input  logic [7:0]        rx_byte,
    input  logic              event_valid,
    input  logic              event_stall,
    input  logic [1:0]        event_kind,
    input  logic signed [8:0] delta_x,
    input  logic signed [9:0] delta_y,
    input  logic signed [7:0] delta_wheel,
    input  logic [2:0]        button_bits,
    input  logic              last_event,
    output int                fail_count,
    output int                pending
);

    typedef struct {
        logic [1:0]        kind;
        logic signed [8:0] dx;
        logic signed [9:0] dy;
        logic signed [7:0] dz;
        logic [2:0]        buttons;
        logic              last;
    } mouse_event_t;

    mouse_event_t expected_events[$];

    logic       wheel_on;
    logic [1:0] frame_pos;
    logic [7:0] frame_bytes [3];
    logic [2:0] stored_buttons;

    task automatic decode_rx(input logic [7:0] rx);
        int           idx;
        int           frame_len;
        int           mx;
        int           my;
        int           mz;
        int           n;
        logic [7:0]   flags;
        logic [2:0]   btn;
        mouse_event_t ev [3];
        idx = int'(frame_pos);
        frame_len = wheel_on ? 4 : 3;
        if (idx == 0 && !rx[SYNC_BIT])
            return;
        if (idx < 3)
            frame_bytes[idx] = rx;
        if (idx + 1 < frame_len)
        begin
            frame_pos = frame_pos + 2'd1;
            return;
        end
        frame_pos = POS_FIRST;
        flags = frame_bytes[0];
        mx = int'(frame_bytes[1]) - (flags[X_SIGN_BIT] ? 256 : 0);
        my = -(int'(frame_bytes[2]) - (flags[Y_SIGN_BIT] ? 256 : 0));
        mz = (wheel_on && idx == 3) ? int'($signed(rx)) : 0;
        if (flags[X_OVF_BIT] || flags[Y_OVF_BIT])
            return;
        btn = flags[2:0];
        n = 0;
        if (mx != 0 || my != 0)
        begin
            ev[n] = '{EV_MOVE, 9'(mx), 10'(my), 8'sd0, btn, 1'b0};
            n++;
        end
        if (btn != stored_buttons)
        begin
            ev[n] = '{EV_BUTTON, 9'sd0, 10'sd0, 8'sd0, btn, 1'b0};
            n++;
            stored_buttons = btn;
        end
        if (mz != 0)
        begin
            ev[n] = '{EV_SCROLL, 9'sd0, 10'sd0, 8'(mz), btn, 1'b0};
            n++;
        end
        if (n > 0)
            ev[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_events.push_back(ev[i]);
    endtask

    task automatic check_event();
        mouse_event_t want;
        if (expected_events.size() == 0)
        begin
            $error("unexpected event: kind %0d", event_kind);
            fail_count++;
            return;
        end
        want = expected_events.pop_front();
        if (event_kind !== want.kind)
        begin
            $error("event_kind: expected %0d, got %0d", want.kind, event_kind);
            fail_count++;
        end
        if (delta_x !== want.dx)
        begin
            $error("delta_x: expected %0d, got %0d", want.dx, delta_x);
            fail_count++;
        end
        if (delta_y !== want.dy)
        begin
            $error("delta_y: expected %0d, got %0d", want.dy, delta_y);
            fail_count++;
        end
        if (delta_wheel !== want.dz)
        begin
            $error("delta_wheel: expected %0d, got %0d", want.dz, delta_wheel);
            fail_count++;
        end
        if (button_bits !== want.buttons)
        begin
            $error("button_bits: expected %0d, got %0d", want.buttons, button_bits);
            fail_count++;
        end
        if (last_event !== want.last)
        begin
            $error("last_event: expected %0d, got %0d", want.last, last_event);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_events.delete();
            wheel_on = 1'b0;
            frame_pos = POS_FIRST;
            frame_bytes[0] = 8'h00;
            frame_bytes[1] = 8'h00;
            frame_bytes[2] = 8'h00;
            stored_buttons = 3'b000;
            pending = 0;
        end
        else
        begin
            if (event_valid && !event_stall)
                check_event();
            if (rx_valid && !rx_stall)
                decode_rx(rx_byte);
            if (cfg_valid && cfg_ready)
                wheel_on = cfg_data;
            pending = expected_events.size();
        end
    end

endmodule

// File: tb/testbench.sv
// Testbench top for the PS/2 mouse packet decoder: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import ps2md_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASE_HALF    = 54;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_data;
    logic              rx_valid;
    logic              rx_stall;
    logic [7:0]        rx_byte;
    logic              event_valid;
    logic              event_stall;
    logic [1:0]        event_kind;
    logic signed [8:0] delta_x;
    logic signed [9:0] delta_y;
    logic signed [7:0] delta_wheel;
    logic [2:0]        button_bits;
    logic              last_event;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   stall_left = 0;
    logic idle_on = 1'b1;
    logic wheel_on = 1'b0;
    logic [2:0] held_buttons = 3'b000;
    logic rx_took = 1'b0;
    logic cfg_took = 1'b0;

    ps2_mouse_packet_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .rx_valid    (rx_valid),
        .rx_stall    (rx_stall),
        .rx_byte     (rx_byte),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_kind  (event_kind),
        .delta_x     (delta_x),
        .delta_y     (delta_y),
        .delta_wheel (delta_wheel),
        .button_bits (button_bits),
        .last_event  (last_event)
    );

    mouse_event_checker event_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .rx_valid    (rx_valid),
        .rx_stall    (rx_stall),
        .rx_byte     (rx_byte),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_kind  (event_kind),
        .delta_x     (delta_x),
        .delta_y     (delta_y),
        .delta_wheel (delta_wheel),
        .button_bits (button_bits),
        .last_event  (last_event),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        rx_took <= rx_valid && !rx_stall;
        cfg_took <= cfg_valid && cfg_ready;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // random output back-pressure in bursts
    always @(negedge clk)
    begin
        if (!idle_on)
        begin
            stall_left = 0;
            event_stall = 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            if (stall_left == 0)
                event_stall = 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 9);
            event_stall = 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] value);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            rx_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        rx_valid = 1'b1;
        rx_byte = value;
        @(negedge clk);
        while (!rx_took)
            @(negedge clk);
    endtask

    task automatic wait_idle(input int settle);
        rx_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_wheel(input logic value);
        wait_idle(SETTLE_CYCLES);
        cfg_valid = 1'b1;
        cfg_data = value;
        @(negedge clk);
        while (!cfg_took)
            @(negedge clk);
        cfg_valid = 1'b0;
        wheel_on = value;
    endtask

    task automatic send_random(input int count);
        int         sent;
        int         pick;
        logic [7:0] flags;
        logic [7:0] mx;
        logic [7:0] my;
        logic [7:0] mz;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                send_byte(8'($urandom) & 8'hF7);
            else if (pick == 1)
            begin
                send_byte(8'($urandom) | 8'h08);
                sent++;
            end
            else
            begin
                flags = 8'($urandom);
                flags[SYNC_BIT] = 1'b1;
                if ($urandom_range(0, 9) != 0)
                    flags[7:6] = 2'b00;
                if ($urandom_range(0, 1) == 0)
                    flags[2:0] = held_buttons;
                mx = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
                my = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
                mz = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
                if (mx == 8'h00 && $urandom_range(0, 1) == 0)
                    flags[X_SIGN_BIT] = 1'b0;
                if (my == 8'h00 && $urandom_range(0, 1) == 0)
                    flags[Y_SIGN_BIT] = 1'b0;
                if (flags[7:6] == 2'b00)
                    held_buttons = flags[2:0];
                send_byte(flags);
                send_byte(mx);
                send_byte(my);
                sent += 3;
                if (wheel_on)
                begin
                    send_byte(mz);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        rx_valid = 1'b0;
        rx_byte = 8'h00;
        event_stall = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // out of sync, empty packet, extremes of motion, overflow, button only
        send_byte(8'h00); send_byte(8'hF7);
        send_byte(8'h08); send_byte(8'h00); send_byte(8'h00);
        send_byte(8'h09); send_byte(8'h01); send_byte(8'hFF);
        send_byte(8'h3F); send_byte(8'h00); send_byte(8'h00);
        send_byte(8'h18); send_byte(8'hFF); send_byte(8'h01);
        send_byte(8'h4F); send_byte(8'h10); send_byte(8'h10);
        send_byte(8'hC8); send_byte(8'h22); send_byte(8'h33);
        send_byte(8'h0C); send_byte(8'h00); send_byte(8'h00);

        // scroll extremes and all three events from one packet
        write_wheel(1'b1);
        send_byte(8'h0C); send_byte(8'h00); send_byte(8'h00); send_byte(8'h7F);
        send_byte(8'h0B); send_byte(8'h05); send_byte(8'h00); send_byte(8'h80);

        // mode changes in the middle of a packet
        send_byte(8'h29); send_byte(8'h00); send_byte(8'h01);
        write_wheel(1'b0);
        send_byte(8'h55);
        send_byte(8'h08); send_byte(8'h02);
        write_wheel(1'b1);
        send_byte(8'h03); send_byte(8'h01);

        for (int phase = 0; phase < 4; phase++)
        begin
            write_wheel(phase[0]);
            if (phase == 3)
                idle_on = 1'b0;
            send_random(PHASE_HALF);
            wait_idle(0);
            send_random(PHASE_HALF);
        end

        wait_idle(SETTLE_CYCLES);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
rtl/ps2md_pkg.sv
rtl/ps2md_front.sv
rtl/ps2md_queue.sv
rtl/ps2md_back.sv
rtl/ps2_mouse_packet_decoder.sv
tb/mouse_event_checker.sv
tb/testbench.sv
